// ----- rtl/battery_adc_to_charge_percent_top_defines.svh -----
// ----------------------------------------------------------------------------
// Battery charge estimator assertion macros
// Shared assertion forms for the checker of the charge estimator.
// ----------------------------------------------------------------------------
`ifndef BATTERY_ADC_TO_CHARGE_PERCENT_TOP_DEFINES_SVH
`define BATTERY_ADC_TO_CHARGE_PERCENT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BACP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define BACP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bacp_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery charge estimator package
// Types, fixed-point constants and the voltage-to-percent curve.
// ----------------------------------------------------------------------------
`default_nettype none

package bacp_pkg;

   localparam int TABLE_CAP          = 64;
   localparam int TABLE_POINTS_DEF   = 23;
   localparam int IDX_W              = 6;
   localparam int MV_W               = 13;
   localparam int PCT_W              = 8;
   localparam int DP_W               = 7;
   localparam int RECIP_W            = 21;
   localparam int SPAN_W             = MV_W + DP_W;
   localparam int SEG_SHIFT          = 24;

   localparam int DEC_PROD_W         = 29;
   localparam int DEC_MUL_W          = 59;
   localparam int MV_DIV_SHIFT       = 46;

   localparam logic [13:0] RAW_FAIL   = 14'h3FFF;
   localparam logic [14:0] MV_STEP    = 15'd26855;
   localparam logic [11:0] MV_OFFSET  = 12'd3840;
   localparam logic [29:0] MV_RECIP   = 30'd703687442;
   localparam logic [12:0] MV_BASE    = 13'd400;
   localparam logic [7:0]  PCT_FAIL   = 8'hFF;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [MV_W-1:0]    mv_type;
   typedef logic [PCT_W-1:0]   pct_type;
   typedef logic [DP_W-1:0]    dp_type;
   typedef logic [RECIP_W-1:0] recip_type;

   typedef struct packed {
      mv_type    mv;
      mv_type    lmv;
      pct_type   lp;
      dp_type    dp;
      recip_type recip;
   } seg_type;

   function automatic mv_type tab_mv(input idx_type idx);
      mv_type v;
      case (idx)
         6'd0:    v = 13'd3000;
         6'd1:    v = 13'd3300;
         6'd2:    v = 13'd3500;
         6'd3:    v = 13'd3610;
         6'd4:    v = 13'd3650;
         6'd5:    v = 13'd3690;
         6'd6:    v = 13'd3710;
         6'd7:    v = 13'd3730;
         6'd8:    v = 13'd3750;
         6'd9:    v = 13'd3770;
         6'd10:   v = 13'd3790;
         6'd11:   v = 13'd3800;
         6'd12:   v = 13'd3820;
         6'd13:   v = 13'd3840;
         6'd14:   v = 13'd3850;
         6'd15:   v = 13'd3870;
         6'd16:   v = 13'd3910;
         6'd17:   v = 13'd3950;
         6'd18:   v = 13'd3980;
         6'd19:   v = 13'd4020;
         6'd20:   v = 13'd4080;
         6'd21:   v = 13'd4110;
         6'd22:   v = 13'd4200;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic pct_type tab_pct(input idx_type idx);
      pct_type v;
      case (idx)
         6'd0:    v = 8'd0;
         6'd1:    v = 8'd3;
         6'd2:    v = 8'd6;
         6'd3:    v = 8'd10;
         6'd4:    v = 8'd13;
         6'd5:    v = 8'd17;
         6'd6:    v = 8'd20;
         6'd7:    v = 8'd25;
         6'd8:    v = 8'd30;
         6'd9:    v = 8'd35;
         6'd10:   v = 8'd40;
         6'd11:   v = 8'd45;
         6'd12:   v = 8'd50;
         6'd13:   v = 8'd55;
         6'd14:   v = 8'd60;
         6'd15:   v = 8'd65;
         6'd16:   v = 8'd70;
         6'd17:   v = 8'd75;
         6'd18:   v = 8'd80;
         6'd19:   v = 8'd85;
         6'd20:   v = 8'd90;
         6'd21:   v = 8'd95;
         6'd22:   v = 8'd100;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Reciprocal of the voltage span of the segment that ends at idx,
   // rounded up at a scale of 2^SEG_SHIFT. Index 0 and indices past the table read as zero.
   function automatic recip_type tab_recip(input idx_type idx);
      recip_type v;
      case (idx)
         6'd1:    v = 21'd55925;
         6'd2:    v = 21'd83887;
         6'd3:    v = 21'd152521;
         6'd4:    v = 21'd419431;
         6'd5:    v = 21'd419431;
         6'd6:    v = 21'd838861;
         6'd7:    v = 21'd838861;
         6'd8:    v = 21'd838861;
         6'd9:    v = 21'd838861;
         6'd10:   v = 21'd838861;
         6'd11:   v = 21'd1677722;
         6'd12:   v = 21'd838861;
         6'd13:   v = 21'd838861;
         6'd14:   v = 21'd1677722;
         6'd15:   v = 21'd838861;
         6'd16:   v = 21'd419431;
         6'd17:   v = 21'd419431;
         6'd18:   v = 21'd559241;
         6'd19:   v = 21'd419431;
         6'd20:   v = 21'd279621;
         6'd21:   v = 21'd559241;
         6'd22:   v = 21'd186414;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bacp_decode.sv -----
// ----------------------------------------------------------------------------
// ADC voltage decoder
// Three-stage pipeline that turns the 14-bit signed ADC code into millivolts.
// ----------------------------------------------------------------------------
`default_nettype none

module bacp_decode (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [7:0]      adc_low,
   input  wire logic [7:0]      adc_high,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output bacp_pkg::mv_type     out_mv
);
   import bacp_pkg::*;

   logic                  a_vld_ff;
   logic                  a_fail_ff;
   logic [DEC_PROD_W-1:0] a_prod_ff;
   logic                  b_vld_ff;
   logic                  b_fail_ff;
   logic [DEC_MUL_W-1:0]  b_prod_ff;
   logic                  c_vld_ff;
   mv_type                c_mv_ff;

   logic                  a_en;
   logic                  b_en;
   logic                  c_en;
   logic [13:0]           raw;
   logic [13:0]           offset_code;
   logic                  a_fail_in;
   logic [DEC_PROD_W-1:0] a_prod_in;
   logic [DEC_PROD_W-1:0] b_num;
   logic [DEC_MUL_W-1:0]  b_prod_in;
   mv_type                c_mv_in;

   assign c_en = !c_vld_ff || out_ready;
   assign b_en = !b_vld_ff || c_en;
   assign a_en = !a_vld_ff || b_en;
   assign in_ready = a_en;

   // The code plus 8192 is the raw word with its sign bit inverted.
   assign raw         = {adc_high[5:0], adc_low};
   assign offset_code = {~raw[13], raw[12:0]};
   assign a_fail_in   = (raw == RAW_FAIL);
   assign a_prod_in   = DEC_PROD_W'(offset_code) * DEC_PROD_W'(MV_STEP);

   assign b_num     = a_prod_ff + DEC_PROD_W'(MV_OFFSET);
   assign b_prod_in = DEC_MUL_W'(b_num) * DEC_MUL_W'(MV_RECIP);

   assign c_mv_in = b_fail_ff ? '0
                  : MV_BASE + b_prod_ff[MV_DIV_SHIFT +: MV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_vld_ff <= in_valid;
         end
         if (b_en) begin
            b_vld_ff <= a_vld_ff;
         end
         if (c_en) begin
            c_vld_ff <= b_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_fail_ff <= a_fail_in;
         a_prod_ff <= a_prod_in;
      end
      if (b_en) begin
         b_fail_ff <= a_fail_ff;
         b_prod_ff <= b_prod_in;
      end
      if (c_en) begin
         c_mv_ff <= c_mv_in;
      end
   end

   assign out_valid = c_vld_ff;
   assign out_mv    = c_mv_ff;

endmodule

`default_nettype wire

// ----- rtl/bacp_seg.sv -----
// ----------------------------------------------------------------------------
// Curve segment lookup
// One pipeline stage that finds the curve segment of a voltage and fetches
// its base point, percent step and span reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module bacp_seg #(
   parameter int TABLE_POINTS = bacp_pkg::TABLE_POINTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bacp_pkg::mv_type  in_mv,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bacp_pkg::seg_type      out_seg
);
   import bacp_pkg::*;

   localparam idx_type LAST = IDX_W'(TABLE_POINTS - 1);

   logic    d_vld_ff;
   seg_type d_seg_ff;

   logic    d_en;
   idx_type seg_idx;
   idx_type low_idx;
   seg_type d_seg_in;

   assign d_en     = !d_vld_ff || out_ready;
   assign in_ready = d_en;

   // The first point at or above the voltage closes its segment.
   always_comb begin
      seg_idx = LAST;
      for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
         if (in_mv <= tab_mv(IDX_W'(i))) begin
            seg_idx = IDX_W'(i);
         end
      end
   end

   assign low_idx = seg_idx - idx_type'(1);

   always_comb begin
      d_seg_in.mv    = in_mv;
      d_seg_in.lmv   = in_mv;
      d_seg_in.dp    = '0;
      d_seg_in.recip = '0;
      if (in_mv == '0) begin
         d_seg_in.lp = PCT_FAIL;
      end else if (in_mv <= tab_mv('0)) begin
         d_seg_in.lp = tab_pct('0);
      end else if (in_mv >= tab_mv(LAST)) begin
         d_seg_in.lp = tab_pct(LAST);
      end else begin
         d_seg_in.lmv   = tab_mv(low_idx);
         d_seg_in.lp    = tab_pct(low_idx);
         d_seg_in.dp    = DP_W'(tab_pct(seg_idx) - tab_pct(low_idx));
         d_seg_in.recip = tab_recip(seg_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (d_en) begin
         d_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (d_en) begin
         d_seg_ff <= d_seg_in;
      end
   end

   assign out_valid = d_vld_ff;
   assign out_seg   = d_seg_ff;

endmodule

`default_nettype wire

// ----- rtl/bacp_interp.sv -----
// ----------------------------------------------------------------------------
// Segment interpolator
// Two pipeline stages: percent step times voltage offset, then division by
// the segment span through its reciprocal and addition of the base percent.
// ----------------------------------------------------------------------------
`default_nettype none

module bacp_interp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bacp_pkg::seg_type in_seg,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bacp_pkg::mv_type       out_mv,
   output bacp_pkg::pct_type      out_pct
);
   import bacp_pkg::*;

   localparam int QUOT_W = SPAN_W + RECIP_W;

   logic              e_vld_ff;
   mv_type            e_mv_ff;
   pct_type           e_lp_ff;
   logic [SPAN_W-1:0] e_span_ff;
   recip_type         e_recip_ff;
   logic              f_vld_ff;
   mv_type            f_mv_ff;
   pct_type           f_pct_ff;

   logic              e_en;
   logic              f_en;
   mv_type            e_diff;
   logic [SPAN_W-1:0] e_span_in;
   logic [QUOT_W-1:0] f_scaled;
   pct_type           f_pct_in;

   assign f_en     = !f_vld_ff || out_ready;
   assign e_en     = !e_vld_ff || f_en;
   assign in_ready = e_en;

   assign e_diff    = in_seg.mv - in_seg.lmv;
   assign e_span_in = SPAN_W'(e_diff) * SPAN_W'(in_seg.dp);

   assign f_scaled = QUOT_W'(e_span_ff) * QUOT_W'(e_recip_ff);
   assign f_pct_in = e_lp_ff + PCT_W'(f_scaled[QUOT_W-1:SEG_SHIFT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else begin
         if (e_en) begin
            e_vld_ff <= in_valid;
         end
         if (f_en) begin
            f_vld_ff <= e_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_en) begin
         e_mv_ff    <= in_seg.mv;
         e_lp_ff    <= in_seg.lp;
         e_span_ff  <= e_span_in;
         e_recip_ff <= in_seg.recip;
      end
      if (f_en) begin
         f_mv_ff  <= e_mv_ff;
         f_pct_ff <= f_pct_in;
      end
   end

   assign out_valid = f_vld_ff;
   assign out_mv    = f_mv_ff;
   assign out_pct   = f_pct_ff;

endmodule

`default_nettype wire

// ----- rtl/battery_adc_to_charge_percent_top.sv -----
// A request passes the decoder, segment lookup and interpolator stages in order to the rsp_ port.
// Throughput: one request per cycle while rsp_ready stays high; every stage holds one request.
// A stage takes a new request whenever it is empty or its successor moves on.
// Reset clears the valid bit of every stage; no request survives reset.
// ----------------------------------------------------------------------------
// Battery charge estimator top level
// Decodes a battery-voltage ADC reading into millivolts and a charge percent
// interpolated from a fixed voltage curve.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_adc_to_charge_percent_top #(
   parameter int TABLE_POINTS = bacp_pkg::TABLE_POINTS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_adc_low,
   input  wire logic [7:0]          req_adc_high,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output bacp_pkg::mv_type         rsp_millivolts,
   output logic signed [7:0]        rsp_charge_percent
);
   import bacp_pkg::*;

   logic    dec_valid;
   logic    dec_ready;
   mv_type  dec_mv;
   logic    seg_valid;
   logic    seg_ready;
   seg_type seg_data;
   pct_type pct;

   bacp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .adc_low   (req_adc_low),
      .adc_high  (req_adc_high),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_mv    (dec_mv)
   );

   bacp_seg #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_seg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_mv     (dec_mv),
      .out_valid (seg_valid),
      .out_ready (seg_ready),
      .out_seg   (seg_data)
   );

   bacp_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (seg_ready),
      .in_seg    (seg_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_mv    (rsp_millivolts),
      .out_pct   (pct)
   );

   assign rsp_charge_percent = signed'(pct);

endmodule

`default_nettype wire

// ----- rtl/bacp_checker.sv -----
// ----------------------------------------------------------------------------
// Battery charge estimator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_adc_to_charge_percent_top_defines.svh"

module bacp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [12:0]       rsp_millivolts,
   input wire logic signed [7:0] rsp_charge_percent
);

   `BACP_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   `BACP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_millivolts) && $stable(rsp_charge_percent), "stalled result changed")

   `BACP_ASSERT_NOW(a_fail_pct, clock, reset, rsp_valid && (rsp_millivolts == 13'd0), rsp_charge_percent == -8'sd1, "failed read without percent of minus one")

   `BACP_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid && (rsp_millivolts != 13'd0), (rsp_charge_percent >= 8'sd0) && (rsp_charge_percent <= 8'sd100) && (rsp_millivolts >= 13'd400) && (rsp_millivolts <= 13'd4799), "result out of range")

endmodule

bind battery_adc_to_charge_percent_top bacp_checker u_bacp_checker (.*);

`default_nettype wire
